/* rtl/tirt_pkg.sv */
package tirt_pkg;

  typedef enum logic [3:0] {
    MODE_CREATE  = 4'd0,
    MODE_CHANGE  = 4'd1,
    MODE_UPDATE  = 4'd2,
    MODE_SCAN    = 4'd3,
    MODE_FORCE   = 4'd4,
    MODE_SKIP    = 4'd5,
    MODE_EXECUTE = 4'd6,
    MODE_RESTART = 4'd7,
    MODE_ENABLE  = 4'd8,
    MODE_DISABLE = 4'd9,
    MODE_DELETE  = 4'd10,
    MODE_EVERY   = 4'd11
  } mode_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [31:0] NO_PERIOD  = 32'hFFFF_FFFF;
  localparam int unsigned MAX_RES    = 16;

  typedef struct packed {
    logic [3:0]         mode;
    logic [3:0]         slot;
    logic [31:0]        now;
    logic signed [31:0] sample;
    logic               execute;
    logic [31:0]        min_interval;
    logic [31:0]        max_interval;
    logic [30:0]        min_change;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot_out;
    logic               fired;
    logic signed [31:0] value_out;
    logic               was_updated;
    logic               was_reported;
    logic               enabled;
    logic               last;
  } out_word_t;

endpackage

/* rtl/threshold_interval_report_table.sv */
// non-scan words pass through S_READ and S_EXEC with busy high; the result is registered in S_EXEC
// scan: after the S_SCAN_RD setup state, one result per cycle for the first NRES slots; the slot loop
// through the shared compare unit sets the rate, and S_FREE then releases deleted slots
// reset clears valid and flag bits of all slots; slot data is written by create
// the receiver cannot stall: each result is shown for one cycle with out_valid
module threshold_interval_report_table
  import tirt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NRES = (SLOTS < MAX_RES) ? SLOTS : MAX_RES;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_SCAN_RD, S_SCAN, S_FREE} state_t;

  logic [SLOTS-1:0] valid_r;
  logic [4:0]       flags_r [SLOTS];
  logic [31:0] cur_mem [SLOTS];
  logic [31:0] rep_mem [SLOTS];
  logic [31:0] lt_mem  [SLOTS];
  logic [31:0] lo_mem  [SLOTS];
  logic [31:0] hi_mem  [SLOTS];
  logic [30:0] th_mem  [SLOTS];

  state_t      state_r;
  in_word_t    req_r;
  logic [SW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic        free_ok_r;
  logic [31:0] cur_q, rep_q, lt_q, lo_q, hi_q;
  logic [30:0] th_q;
  logic [SW-1:0] rd_addr;

  // free slot search
  logic [SW-1:0] free_idx;
  logic          free_found;
  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  // shared unit: elapsed time and change test
  logic [31:0] el;
  logic signed [32:0] diff;
  logic [32:0] adiff;
  logic minor, fire_t;
  assign el = req_r.now - lt_q;
  assign diff = {cur_q[31], cur_q} - {rep_q[31], rep_q};
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
  assign minor = (adiff == '0) || (adiff < {2'b0, th_q});
  assign fire_t = !(el < lo_q) && !(minor && ((el < hi_q) || (hi_q == NO_PERIOD)));

  logic [31:0] lo_set, hi_set;
  assign lo_set = (req_r.min_interval == '0) ? 32'd1 : req_r.min_interval;
  assign hi_set = (req_r.max_interval < lo_set) ? lo_set : req_r.max_interval;

  logic in_range;
  assign in_range = ({28'd0, req_r.slot} < 32'(SLOTS));

  assign rd_addr = (state_r == S_SCAN_RD) ? '0 :
                   (state_r == S_SCAN) ? SW'(idx_r + SW'(1)) :
                   (state_r == S_IDLE) ? SW'(in_word.slot) : SW'(req_r.slot);
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    cur_q <= cur_mem[rd_addr];
    rep_q <= rep_mem[rd_addr];
    lt_q  <= lt_mem[rd_addr];
    lo_q  <= lo_mem[rd_addr];
    hi_q  <= hi_mem[rd_addr];
    th_q  <= th_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      for (int i = 0; i < SLOTS; i++) flags_r[i] <= '0;
      out_valid <= 1'b0;
      idx_r     <= '0;
      cnt_r     <= '0;
      free_ok_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid <= 1'b0;
          if (start) begin
            req_r <= in_word;
            idx_r <= '0;
            cnt_r <= '0;
            state_r <= (in_word.mode == MODE_SCAN) ? S_SCAN_RD : S_READ;
          end
        end
        S_READ: begin
          out_valid <= 1'b0;
          free_ok_r <= free_found;
          idx_r <= free_idx;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          out_word_t o;
          o = '0;
          o.last = 1'b1;
          o.slot_out = req_r.slot;
          o.status = ST_INVALID;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
          if (req_r.mode == MODE_CREATE) begin
            o.slot_out = 4'(idx_r);
            if (!free_ok_r) begin
              o.status = ST_FULL;
              o.slot_out = '0;
            end else begin
              o.status = ST_OK;
              o.enabled = 1'b1;
              valid_r[idx_r] <= 1'b1;
              flags_r[idx_r] <= 5'b00100;
              cur_mem[idx_r] <= '0;
              rep_mem[idx_r] <= '0;
              lt_mem[idx_r]  <= req_r.now;
              lo_mem[idx_r]  <= lo_set;
              hi_mem[idx_r]  <= hi_set;
              th_mem[idx_r]  <= req_r.min_change;
            end
          end else if (req_r.mode <= MODE_EVERY && in_range && valid_r[SW'(req_r.slot)]) begin
            logic [SW-1:0] s;
            logic [4:0] f;
            logic [31:0] v;
            s = SW'(req_r.slot);
            f = flags_r[s];
            v = cur_q;
            unique case (req_r.mode)
              MODE_CHANGE: begin
                lo_mem[s] <= lo_set;
                hi_mem[s] <= hi_set;
                th_mem[s] <= req_r.min_change;
              end
              MODE_UPDATE: begin
                v = req_r.sample;
                cur_mem[s] <= req_r.sample;
                if (!f[0]) begin
                  rep_mem[s] <= req_r.sample;
                  if (req_r.execute && hi_q != NO_PERIOD) lt_mem[s] <= req_r.now - hi_q;
                end
                f[0] = 1'b1;
              end
              MODE_FORCE: lt_mem[s] <= req_r.now - hi_q;
              MODE_SKIP: begin
                lt_mem[s] <= req_r.now;
                rep_mem[s] <= cur_q;
                f[3] = 1'b0;
              end
              MODE_EXECUTE: begin
                lt_mem[s] <= req_r.now;
                rep_mem[s] <= cur_q;
                f[3] = 1'b1;
              end
              MODE_RESTART: begin
                f[0] = 1'b0;
                lt_mem[s] <= req_r.now;
              end
              MODE_ENABLE: f[2] = 1'b1;
              MODE_DISABLE: f[2] = 1'b0;
              MODE_DELETE: begin
                f[2] = 1'b0;
                f[4] = 1'b1;
              end
              MODE_EVERY: hi_mem[s] <= (req_r.max_interval < lo_q) ? lo_q : req_r.max_interval;
              default: ;
            endcase
            flags_r[s] <= f;
            o.status = ST_OK;
            o.value_out = v;
            o.was_updated = f[0];
            o.was_reported = f[1];
            o.enabled = f[2];
          end
          out_word <= o;
        end
        S_SCAN_RD: begin
          out_valid <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          logic [4:0] f;
          logic fr;
          f = flags_r[idx_r];
          fr = 1'b0;
          if (valid_r[idx_r]) begin
            if (fire_t) begin
              lt_mem[idx_r]  <= req_r.now;
              rep_mem[idx_r] <= cur_q;
              if (f[0] && f[2]) f = f | 5'b01010;
            end
            if (f[3]) begin
              f[3] = 1'b0;
              fr = !f[4];
            end
            flags_r[idx_r] <= f;
          end
          out_valid <= (cnt_r < CW'(NRES));
          if (cnt_r < CW'(NRES)) begin
            out_word.status <= valid_r[idx_r] ? ST_OK : ST_INVALID;
            out_word.slot_out <= 4'(idx_r);
            out_word.fired <= fr;
            out_word.value_out <= valid_r[idx_r] ? cur_q : '0;
            out_word.was_updated <= valid_r[idx_r] & f[0];
            out_word.was_reported <= valid_r[idx_r] & f[1];
            out_word.enabled <= valid_r[idx_r] & f[2];
            out_word.last <= (cnt_r == CW'(NRES - 1));
          end
          cnt_r <= cnt_r + CW'(1);
          idx_r <= SW'(idx_r + SW'(1));
          if (cnt_r == CW'(SLOTS - 1)) state_r <= S_FREE;
        end
        S_FREE: begin
          out_valid <= 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (valid_r[i] && flags_r[i][4]) begin
              valid_r[i] <= 1'b0;
              flags_r[i] <= '0;
            end
          end
          state_r <= S_IDLE;
        end
        default: begin
          out_valid <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import tirt_pkg::*;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  class report_scoreboard;
    bit        valid_q[NSLOT];
    bit [5:0]  flags_q[NSLOT];
    bit [31:0] value_q[NSLOT];
    bit [31:0] reported_q[NSLOT];
    bit [31:0] stamp_q[NSLOT];
    bit [31:0] lo_q[NSLOT];
    bit [31:0] hi_q[NSLOT];
    bit [30:0] thresh_q[NSLOT];
    out_word_t pending_q[$];
    int        errors;

    function void put_intervals(int s, bit [31:0] lo, bit [31:0] hi, bit [30:0] th);
      if (lo == 0) lo = 1;
      if (hi < lo) hi = lo;
      lo_q[s] = lo;
      hi_q[s] = hi;
      thresh_q[s] = th;
    endfunction

    function out_word_t make_word(bit [1:0] st, bit [3:0] s, bit f, bit show, bit lst);
      out_word_t w;
      w = '0;
      w.status = st;
      w.slot_out = s;
      w.fired = f;
      w.last = lst;
      if (show) begin
        w.value_out = value_q[s];
        w.was_updated = flags_q[s][0];
        w.was_reported = flags_q[s][1];
        w.enabled = flags_q[s][2];
      end
      return w;
    endfunction

    function bit below_threshold(int s);
      longint d;
      d = longint'($signed(value_q[s])) - longint'($signed(reported_q[s]));
      if (d < 0) d = -d;
      return d == 0 || d < longint'(thresh_q[s]);
    endfunction

    function void note_input(in_word_t w);
      bit [31:0] el;
      bit fired[NSLOT];
      int s;
      int f;
      s = w.slot;
      if (w.mode == MODE_SCAN) begin
        for (int i = 0; i < NSLOT; i++) begin
          fired[i] = 0;
          if (!valid_q[i]) continue;
          el = w.now - stamp_q[i];
          if (el < lo_q[i]) continue;
          if (below_threshold(i) && (el < hi_q[i] || hi_q[i] == NO_PERIOD)) continue;
          stamp_q[i] = w.now;
          reported_q[i] = value_q[i];
          if (!flags_q[i][0] || !flags_q[i][2]) continue;
          flags_q[i] |= 6'b001010;
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (!valid_q[i] || !flags_q[i][3]) continue;
          flags_q[i][3] = 0;
          if (!flags_q[i][4]) fired[i] = 1;
        end
        for (int i = 0; i < NSLOT; i++)
          pending_q.push_back(make_word(valid_q[i] ? ST_OK : ST_INVALID, 4'(i), fired[i],
                                        valid_q[i], i == NSLOT - 1));
        for (int i = 0; i < NSLOT; i++)
          if (valid_q[i] && flags_q[i][4]) begin
            valid_q[i] = 0;
            flags_q[i] = 0;
          end
        return;
      end
      if (w.mode == MODE_CREATE) begin
        f = NSLOT;
        for (int i = NSLOT - 1; i >= 0; i--) if (!valid_q[i]) f = i;
        if (f == NSLOT) begin
          pending_q.push_back(make_word(ST_FULL, 4'd0, 1'b0, 1'b0, 1'b1));
          return;
        end
        valid_q[f] = 1;
        flags_q[f] = 6'b000100;
        value_q[f] = 0;
        reported_q[f] = 0;
        stamp_q[f] = w.now;
        put_intervals(f, w.min_interval, w.max_interval, w.min_change);
        pending_q.push_back(make_word(ST_OK, 4'(f), 1'b0, 1'b1, 1'b1));
        return;
      end
      if (w.mode > MODE_EVERY || !valid_q[s]) begin
        pending_q.push_back(make_word(ST_INVALID, 4'(s), 1'b0, 1'b0, 1'b1));
        return;
      end
      case (w.mode)
        MODE_CHANGE: put_intervals(s, w.min_interval, w.max_interval, w.min_change);
        MODE_UPDATE: begin
          value_q[s] = w.sample;
          if (!flags_q[s][0]) begin
            reported_q[s] = w.sample;
            if (w.execute && hi_q[s] != NO_PERIOD) stamp_q[s] = w.now - hi_q[s];
          end
          flags_q[s][0] = 1;
        end
        MODE_FORCE: stamp_q[s] = w.now - hi_q[s];
        MODE_SKIP: begin
          stamp_q[s] = w.now;
          reported_q[s] = value_q[s];
          flags_q[s][3] = 0;
        end
        MODE_EXECUTE: begin
          stamp_q[s] = w.now;
          reported_q[s] = value_q[s];
          flags_q[s][3] = 1;
        end
        MODE_RESTART: begin
          flags_q[s][0] = 0;
          stamp_q[s] = w.now;
        end
        MODE_ENABLE: flags_q[s][2] = 1;
        MODE_DISABLE: flags_q[s][2] = 0;
        MODE_DELETE: begin
          flags_q[s][2] = 0;
          flags_q[s][4] = 1;
        end
        default: hi_q[s] = w.max_interval < lo_q[s] ? lo_q[s] : w.max_interval;
      endcase
      pending_q.push_back(make_word(ST_OK, 4'(s), 1'b0, 1'b1, 1'b1));
    endfunction

    function void report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s at %0t", what, $time);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.status !== exp_w.status) report_mismatch("status");
      if (got.slot_out !== exp_w.slot_out) report_mismatch("slot_out");
      if (got.fired !== exp_w.fired) report_mismatch("fired");
      if (got.value_out !== exp_w.value_out) report_mismatch("value_out");
      if (got.was_updated !== exp_w.was_updated) report_mismatch("was_updated");
      if (got.was_reported !== exp_w.was_reported) report_mismatch("was_reported");
      if (got.enabled !== exp_w.enabled) report_mismatch("enabled");
      if (got.last !== exp_w.last) report_mismatch("last");
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  report_scoreboard board = new();
  int        idle_cycles = 0;
  bit [31:0] clock_ms = 0;

  threshold_interval_report_table i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_word);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t w, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 7) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_input(w);
  endtask

  task automatic wait_drained();
    start <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_word_t random_word(mode_t m, bit [3:0] s);
    in_word_t w;
    w.mode = m;
    w.slot = s;
    w.now = clock_ms;
    w.sample = 32'($urandom_range(0, 3) == 0 ? $urandom :
                   $signed($urandom_range(0, 400000)) - 200000);
    w.execute = 1'($urandom_range(0, 1));
    w.min_interval = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 60);
    w.max_interval = $urandom_range(0, 5) == 0 ? NO_PERIOD :
                     ($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 200));
    w.min_change = 31'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 100000));
    return w;
  endfunction

  task automatic send_mode(mode_t m, bit [3:0] s, bit allow_gap);
    send_word(random_word(m, s), allow_gap);
  endtask

  initial begin
    in_word_t w;
    int r;
    bit [3:0] s;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    send_mode(MODE_FORCE, 4'd3, 0);
    w = random_word(MODE_CREATE, 0);
    w.min_interval = 0; w.max_interval = 0; w.min_change = '1; w.now = '1;
    send_word(w, 0);
    w = random_word(MODE_CREATE, 0);
    w.min_interval = '1; w.max_interval = NO_PERIOD; w.min_change = 0; w.now = 0;
    send_word(w, 0);
    w = random_word(MODE_UPDATE, 0);
    w.sample = 32'sh7FFF_FFFF; w.execute = 1;
    send_word(w, 0);
    w.slot = 1; w.sample = 32'sh8000_0000;
    send_word(w, 0);
    send_mode(MODE_SCAN, 0, 0);
    for (int m = 1; m <= 11; m++) send_mode(mode_t'(m), 4'd0, 0);
    w = '0; w.mode = 4'd12; w.slot = 4'd15; send_word(w, 0);
    w.mode = 4'd15; w.slot = 4'd0; send_word(w, 0);
    for (int i = 0; i < 15; i++) send_mode(MODE_CREATE, 0, 0);
    send_mode(MODE_SCAN, 0, 0);
    wait_drained();

    // random
    for (int n = 0; n < 440; n++) begin
      clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 80);
      s = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < 10) send_mode(MODE_CREATE, s, n % 60 > 20);
      else if (r < 35) send_mode(MODE_UPDATE, s, n % 60 > 20);
      else if (r < 50) send_mode(MODE_SCAN, s, n % 60 > 20);
      else if (r < 54) send_word(random_word(mode_t'($urandom_range(0, 15)), s), 1);
      else send_mode(mode_t'($urandom_range(1, 11)), s, n % 60 > 20);
      if (n == 200) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
